// ----- sv/source_lexer_char_classifier_defines.svh -----
// Assertion macros shared by the lexer checker.
// Each macro expects clk and rst to be visible where it is used.
`ifndef SOURCE_LEXER_CHAR_CLASSIFIER_DEFINES_SVH
`define SOURCE_LEXER_CHAR_CLASSIFIER_DEFINES_SVH

// same-cycle implication
`define SLC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/slc_pkg.sv -----
// Shared types and constants for the source lexer character classifier.
// No dependencies; used by every module of the block.
package slc_pkg;

  localparam int LineW = 16;
  localparam int MaxEv = 3;

  typedef enum logic [3:0] {
    CL_INT  = 4'd0,
    CL_DBL  = 4'd1,
    CL_PDBL = 4'd2,
    CL_OP   = 4'd3,
    CL_STR  = 4'd4,
    CL_ID   = 4'd5,
    CL_PCOM = 4'd6,
    CL_COM  = 4'd7,
    CL_IDLE = 4'd8,
    CL_ESC  = 4'd9
  } lex_class_t;

  typedef enum logic [1:0] {
    EV_APPEND = 2'd0,
    EV_END    = 2'd1,
    EV_ERR    = 2'd2
  } ev_kind_t;

  localparam logic [7:0] ChN     = 8'h6e;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;

  typedef struct packed {
    ev_kind_t   kind;
    logic [2:0] cls;
    logic [7:0] ch;
  } ev_t;

  // all events one item produces, in emission order
  typedef struct packed {
    ev_t [MaxEv-1:0]  ev;
    logic [1:0]       count;
    logic [LineW-1:0] line;
  } bundle_t;

  function automatic logic is_operator(input logic [7:0] c);
    return (c == 8'h7b) || (c == 8'h7d) || (c == 8'h28) || (c == 8'h29) ||
           (c == 8'h3d) || (c == 8'h2d) || (c == 8'h3b) || (c == 8'h2c);
  endfunction

endpackage

// ----- sv/slc_lexer.sv -----
// Token class state machine and line counter; builds the event bundle of one item.
// Depends on slc_pkg.
module slc_lexer (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic            cmd,
  input  logic [7:0]      char_byte,
  output slc_pkg::bundle_t bundle
);

  slc_pkg::lex_class_t           cls, cls_next;
  logic [slc_pkg::LineW-1:0]     line, line_next;

  logic                do_end, do_app, do_err, do_op;
  logic [3:0]          app_cls;
  logic [7:0]          app_ch;
  logic [3:0]          end_cls;
  logic                cur_idle;
  logic [1:0]          n;

  always_comb begin
    cls_next = cls;
    line_next = line;
    do_end = 1'b0;
    do_app = 1'b0;
    do_err = 1'b0;
    do_op  = 1'b0;
    app_cls = cls;
    app_ch = char_byte;
    if (cmd) begin
      do_end = 1'b1;
      cls_next = slc_pkg::CL_IDLE;
      line_next = {{(slc_pkg::LineW-1){1'b0}}, 1'b1};
    end else if (cls == slc_pkg::CL_ESC) begin
      cls_next = slc_pkg::CL_STR;
      app_cls = slc_pkg::CL_STR;
      do_app = 1'b1;
      priority if (char_byte == slc_pkg::ChN) begin
        app_ch = slc_pkg::ChLf;
      end else if (char_byte == slc_pkg::ChR) begin
        app_ch = slc_pkg::ChCr;
      end else if (char_byte == slc_pkg::ChT) begin
        app_ch = slc_pkg::ChTab;
      end else if (char_byte == slc_pkg::ChBslash) begin
        app_ch = slc_pkg::ChBslash;
      end else begin
        do_app = 1'b0;
        do_err = 1'b1;
      end
    end else if (char_byte == slc_pkg::ChCr || char_byte == slc_pkg::ChLf) begin
      if (cls == slc_pkg::CL_COM) begin
        do_end = 1'b1;
        cls_next = slc_pkg::CL_IDLE;
      end
      if (line != '1) line_next = line + 1'b1;
    end else if (cls == slc_pkg::CL_COM) begin
      do_app = 1'b1;
    end else if (char_byte >= 8'h30 && char_byte <= 8'h39) begin
      if (cls == slc_pkg::CL_IDLE) cls_next = slc_pkg::CL_INT;
      else if (cls == slc_pkg::CL_PDBL) cls_next = slc_pkg::CL_DBL;
      app_cls = cls_next;
      do_app = 1'b1;
    end else if (char_byte == slc_pkg::ChDot && (cls == slc_pkg::CL_IDLE ||
                 cls == slc_pkg::CL_INT || cls == slc_pkg::CL_STR)) begin
      if (cls == slc_pkg::CL_IDLE) cls_next = slc_pkg::CL_PDBL;
      else if (cls == slc_pkg::CL_INT) cls_next = slc_pkg::CL_DBL;
      app_cls = cls_next;
      do_app = 1'b1;
    end else if (char_byte == slc_pkg::ChDot || slc_pkg::is_operator(char_byte) ||
                 char_byte == slc_pkg::ChBslash) begin
      if (cls == slc_pkg::CL_STR) begin
        // backslash in a string opens an escape, other operators are text
        if (char_byte == slc_pkg::ChBslash) cls_next = slc_pkg::CL_ESC;
        else do_app = 1'b1;
      end else begin
        do_end = 1'b1;
        do_app = 1'b1;
        app_cls = slc_pkg::CL_OP;
        do_op = 1'b1;
        cls_next = slc_pkg::CL_IDLE;
      end
    end else if (char_byte == slc_pkg::ChSpace || char_byte == slc_pkg::ChTab) begin
      if (cls == slc_pkg::CL_STR) begin
        do_app = 1'b1;
      end else begin
        do_end = 1'b1;
        cls_next = slc_pkg::CL_IDLE;
      end
    end else if (char_byte == slc_pkg::ChQuote) begin
      do_end = 1'b1;
      if (cls == slc_pkg::CL_STR) begin
        cls_next = slc_pkg::CL_IDLE;
      end else begin
        cls_next = slc_pkg::CL_STR;
        app_cls = slc_pkg::CL_STR;
        do_app = 1'b1;
      end
    end else if (char_byte == slc_pkg::ChSlash) begin
      if (cls == slc_pkg::CL_STR) begin
        do_app = 1'b1;
      end else if (cls == slc_pkg::CL_PCOM) begin
        cls_next = slc_pkg::CL_COM;
      end else begin
        do_end = 1'b1;
        cls_next = slc_pkg::CL_PCOM;
        app_cls = slc_pkg::CL_PCOM;
        do_app = 1'b1;
      end
    end else begin
      if (cls == slc_pkg::CL_IDLE || cls == slc_pkg::CL_INT || cls == slc_pkg::CL_DBL) begin
        do_end = 1'b1;
        cls_next = slc_pkg::CL_ID;
      end
      app_cls = cls_next;
      do_app = 1'b1;
    end
  end

  assign cur_idle = (cls == slc_pkg::CL_IDLE);
  assign end_cls  = (cls == slc_pkg::CL_ESC) ? slc_pkg::CL_STR : cls;

  // pack the events in emission order
  always_comb begin
    bundle = '0;
    n = 2'd0;
    if (do_end && !cur_idle) begin
      bundle.ev[n] = '{kind: slc_pkg::EV_END, cls: end_cls[2:0], ch: 8'd0};
      n = n + 2'd1;
    end
    if (do_app) begin
      bundle.ev[n] = '{kind: slc_pkg::EV_APPEND, cls: app_cls[2:0], ch: app_ch};
      n = n + 2'd1;
    end
    if (do_err) begin
      bundle.ev[n] = '{kind: slc_pkg::EV_ERR, cls: 3'(slc_pkg::CL_STR), ch: 8'd0};
      n = n + 2'd1;
    end
    if (do_op) begin
      bundle.ev[n] = '{kind: slc_pkg::EV_END, cls: 3'(slc_pkg::CL_OP), ch: 8'd0};
      n = n + 2'd1;
    end
    bundle.count = n;
    bundle.line = line;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls <= slc_pkg::CL_IDLE;
      line <= {{(slc_pkg::LineW-1){1'b0}}, 1'b1};
    end else if (take) begin
      cls <= cls_next;
      line <= line_next;
    end
  end

endmodule

// ----- sv/slc_serializer.sv -----
// Holds one item's event bundle and sends its events out one per cycle while m_tready allows.
// Depends on slc_pkg.
module slc_serializer (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  slc_pkg::bundle_t bundle_in,
  output logic             free,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [1:0]       m_tuser,  // event_kind
  output logic [31:0]      m_tdata,  // token_class[2:0], char_value[10:3], line_number[26:11]
  output logic             m_tlast   // last_event
);

  slc_pkg::bundle_t bund;
  logic             bvalid;
  logic [1:0]       idx;
  logic             out_load;
  logic             is_last;
  slc_pkg::ev_t     cur_ev;

  assign out_load = !m_tvalid || m_tready;
  assign is_last  = (idx == bund.count - 2'd1);
  assign cur_ev   = bund.ev[idx];
  // a new bundle may enter while the last event of the old one moves out
  assign free     = !bvalid || (out_load && is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= 1'b0;
      idx <= 2'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= bvalid;
        if (bvalid) begin
          m_tuser <= cur_ev.kind;
          m_tdata <= {5'd0, bund.line, cur_ev.ch, cur_ev.cls};
          m_tlast <= is_last;
        end
      end
      if (load && bundle_in.count != 2'd0) begin
        bvalid <= 1'b1;
        bund <= bundle_in;
        idx <= 2'd0;
      end else if (out_load && bvalid) begin
        idx <= is_last ? 2'd0 : idx + 2'd1;
        if (is_last) bvalid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/source_lexer_char_classifier.sv -----
// Character-serial lexer front end: each accepted item (a source character, or a flush
// when s_tuser is set) updates the token class and line count and yields zero to three
// events, which leave one per cycle through the output register when m_tready allows.
// Items without events are taken whenever the single-entry event buffer ahead of the
// output register is free; an item with events holds that buffer until its last event
// moves out, and the next item may enter as that last event leaves. Events pass
// through the event buffer and then the output register.
// Depends on slc_pkg, slc_lexer and slc_serializer.
module source_lexer_char_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic        s_tuser,   // cmd
  input  logic [7:0]  s_tdata,   // char_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [1:0]  m_tuser,   // event_kind
  output logic [31:0] m_tdata,   // token_class[2:0], char_value[10:3], line_number[26:11]
  output logic        m_tlast    // last_event
);

  logic             take;
  slc_pkg::bundle_t bundle;

  assign take = s_tvalid && s_tready;

  slc_lexer u_lexer (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .cmd       (s_tuser),
    .char_byte (s_tdata),
    .bundle    (bundle)
  );

  slc_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .bundle_in (bundle),
    .free      (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

// ----- sv/slc_checker.sv -----
// Port-level checks for the lexer classifier, bound to the top level.
// Depends on slc_pkg and source_lexer_char_classifier_defines.svh.
`include "source_lexer_char_classifier_defines.svh"

module slc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [1:0]  m_tuser,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  `SLC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
    "output item changed while stalled")

  // an escape error is string class, carries no character and ends the item
  `SLC_ASSERT_IMP(a_err_form, m_tvalid && m_tuser == slc_pkg::EV_ERR,
    m_tdata[2:0] == 3'(slc_pkg::CL_STR) && m_tdata[10:3] == 8'd0 && m_tlast,
    "malformed escape error item")

  `SLC_ASSERT_IMP(a_end_nochar, m_tvalid && m_tuser == slc_pkg::EV_END,
    m_tdata[10:3] == 8'd0, "token end carries a character")

  `SLC_ASSERT_IMP(a_line_nz, m_tvalid, m_tdata[26:11] != 16'd0,
    "line number is zero")

endmodule

bind source_lexer_char_classifier slc_checker u_slc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tuser  (m_tuser),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ----- tb/sv/source_lexer_char_classifier_tb.sv -----
// Self-checking testbench for source_lexer_char_classifier: a queue-fed stream driver,
// a stalling monitor and a local model of the token-class state machine.
// Depends on slc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module source_lexer_char_classifier_tb;

  typedef struct packed {
    logic       flush;
    logic [7:0] ch;
  } src_item_t;

  typedef struct packed {
    slc_pkg::ev_kind_t         kind;
    logic [2:0]                cls;
    logic [7:0]                ch;
    logic [slc_pkg::LineW-1:0] line;
    logic                      last;
  } lex_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic        s_tuser = 1'b0;    // cmd
  logic [7:0]  s_tdata = 8'h00;   // char_byte[7:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [1:0]  m_tuser;           // event_kind
  logic [31:0] m_tdata;           // token_class[2:0], char_value[10:3], line_number[26:11]
  logic        m_tlast;           // last_event

  source_lexer_char_classifier uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  src_item_t  src_items[$];
  lex_event_t lex_events_due[$];
  lex_event_t step_events[$];
  lex_event_t want;
  int         mismatches = 0;

  // ---------------------------------------------------------------- lexer model
  slc_pkg::lex_class_t       lex_cls = slc_pkg::CL_IDLE;
  logic [slc_pkg::LineW-1:0] line_cnt = slc_pkg::LineW'(1);

  task automatic emit_event(input slc_pkg::ev_kind_t kind, input slc_pkg::lex_class_t cls,
                            input logic [7:0] ch);
    lex_event_t e;
    e.kind = kind;
    e.cls  = 3'(cls);
    e.ch   = ch;
    e.line = line_cnt;
    e.last = 1'b0;
    if (step_events.size() < slc_pkg::MaxEv)
      step_events = {step_events, e};
  endtask

  task automatic close_token();
    if (lex_cls != slc_pkg::CL_IDLE)
      emit_event(slc_pkg::EV_END,
                 (lex_cls == slc_pkg::CL_ESC) ? slc_pkg::CL_STR : lex_cls, 8'h00);
    lex_cls = slc_pkg::CL_IDLE;
  endtask

  task automatic operator_token(input logic [7:0] ch);
    close_token();
    emit_event(slc_pkg::EV_APPEND, slc_pkg::CL_OP, ch);
    lex_cls = slc_pkg::CL_IDLE;
    emit_event(slc_pkg::EV_END, slc_pkg::CL_OP, 8'h00);
  endtask

  task automatic lex_step(input src_item_t it);
    slc_pkg::lex_class_t c;
    logic [7:0] ch;
    step_events.delete();
    ch = it.ch;
    c = lex_cls;
    if (it.flush) begin
      close_token();
      line_cnt = slc_pkg::LineW'(1);
    end else if (c == slc_pkg::CL_ESC) begin
      lex_cls = slc_pkg::CL_STR;
      case (ch)
        slc_pkg::ChN:      emit_event(slc_pkg::EV_APPEND, slc_pkg::CL_STR, slc_pkg::ChLf);
        slc_pkg::ChR:      emit_event(slc_pkg::EV_APPEND, slc_pkg::CL_STR, slc_pkg::ChCr);
        slc_pkg::ChT:      emit_event(slc_pkg::EV_APPEND, slc_pkg::CL_STR, slc_pkg::ChTab);
        slc_pkg::ChBslash: emit_event(slc_pkg::EV_APPEND, slc_pkg::CL_STR, slc_pkg::ChBslash);
        default:           emit_event(slc_pkg::EV_ERR, slc_pkg::CL_STR, 8'h00);
      endcase
    end else if (ch == slc_pkg::ChCr || ch == slc_pkg::ChLf) begin
      // a line break closes a comment with the old line number
      if (c == slc_pkg::CL_COM)
        close_token();
      if (line_cnt != '1)
        line_cnt++;
    end else if (c == slc_pkg::CL_COM) begin
      emit_event(slc_pkg::EV_APPEND, lex_cls, ch);
    end else begin
      case (ch)
        "0", "1", "2", "3", "4", "5", "6", "7", "8", "9": begin
          if (c == slc_pkg::CL_IDLE)
            lex_cls = slc_pkg::CL_INT;
          else if (c == slc_pkg::CL_PDBL)
            lex_cls = slc_pkg::CL_DBL;
          emit_event(slc_pkg::EV_APPEND, lex_cls, ch);
        end
        slc_pkg::ChDot: begin
          if (c == slc_pkg::CL_IDLE) begin
            lex_cls = slc_pkg::CL_PDBL;
            emit_event(slc_pkg::EV_APPEND, lex_cls, ch);
          end else if (c == slc_pkg::CL_INT) begin
            lex_cls = slc_pkg::CL_DBL;
            emit_event(slc_pkg::EV_APPEND, lex_cls, ch);
          end else if (c == slc_pkg::CL_STR) begin
            emit_event(slc_pkg::EV_APPEND, lex_cls, ch);
          end else begin
            operator_token(ch);
          end
        end
        "{", "}", "(", ")", "=", "-", ";", ",": begin
          if (c == slc_pkg::CL_STR)
            emit_event(slc_pkg::EV_APPEND, lex_cls, ch);
          else
            operator_token(ch);
        end
        slc_pkg::ChSpace, slc_pkg::ChTab: begin
          if (c == slc_pkg::CL_STR)
            emit_event(slc_pkg::EV_APPEND, lex_cls, ch);
          else
            close_token();
        end
        slc_pkg::ChQuote: begin
          close_token();
          if (c != slc_pkg::CL_STR) begin
            lex_cls = slc_pkg::CL_STR;
            emit_event(slc_pkg::EV_APPEND, lex_cls, ch);
          end
        end
        slc_pkg::ChBslash: begin
          if (c == slc_pkg::CL_STR)
            lex_cls = slc_pkg::CL_ESC;
          else
            operator_token(ch);
        end
        slc_pkg::ChSlash: begin
          if (c == slc_pkg::CL_STR) begin
            emit_event(slc_pkg::EV_APPEND, lex_cls, ch);
          end else if (c == slc_pkg::CL_PCOM) begin
            lex_cls = slc_pkg::CL_COM;
          end else begin
            close_token();
            lex_cls = slc_pkg::CL_PCOM;
            emit_event(slc_pkg::EV_APPEND, lex_cls, ch);
          end
        end
        default: begin
          if (c == slc_pkg::CL_IDLE || c == slc_pkg::CL_INT || c == slc_pkg::CL_DBL) begin
            close_token();
            lex_cls = slc_pkg::CL_ID;
          end
          emit_event(slc_pkg::EV_APPEND, lex_cls, ch);
        end
      endcase
    end
    if (step_events.size() > 0)
      step_events[step_events.size() - 1].last = 1'b1;
    foreach (step_events[i])
      lex_events_due = {lex_events_due, step_events[i]};
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic push_char(input logic [7:0] ch);
    src_item_t it;
    it.flush = 1'b0;
    it.ch = ch;
    src_items = {src_items, it};
  endtask

  task automatic push_flush();
    src_item_t it;
    it.flush = 1'b1;
    it.ch = 8'($urandom_range(0, 255));
    src_items = {src_items, it};
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i]);
  endtask

  function automatic logic [7:0] pick_char(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // mostly well-formed tokens with random content, some noise
  task automatic add_token();
    int n;
    logic [7:0] ch;
    case ($urandom_range(0, 11))
      0, 1: begin
        repeat ($urandom_range(1, 4)) push_char(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 1)) begin
          push_char(slc_pkg::ChDot);
          repeat ($urandom_range(0, 3)) push_char(8'("0" + $urandom_range(0, 9)));
        end
      end
      2: begin
        push_char(slc_pkg::ChDot);
        repeat ($urandom_range(0, 3)) push_char(8'("0" + $urandom_range(0, 9)));
      end
      3: begin
        push_char(pick_char("abcxyzQRT_"));
        repeat ($urandom_range(0, 4)) push_char(pick_char("abmnrtz09_XY"));
      end
      4: push_char(pick_char("{}()=-;,.\\"));
      5, 6: begin
        push_char(slc_pkg::ChQuote);
        n = $urandom_range(0, 6);
        repeat (n) begin
          case ($urandom_range(0, 9))
            0, 1: begin
              push_char(slc_pkg::ChBslash);
              push_char(pick_char("nrt\\nrt\\aq\"0"));
            end
            2: push_char(8'($urandom_range(128, 255)));
            3: push_char(pick_char(" \t/.{=\r\n"));
            default: begin
              ch = 8'($urandom_range(32, 126));
              push_char((ch == slc_pkg::ChQuote || ch == slc_pkg::ChBslash) ? "s" : ch);
            end
          endcase
        end
        if ($urandom_range(0, 7) != 0)
          push_char(slc_pkg::ChQuote);
      end
      7: begin
        push_char(slc_pkg::ChSlash);
        if ($urandom_range(0, 3) != 0) begin
          push_char(slc_pkg::ChSlash);
          repeat ($urandom_range(0, 5)) begin
            ch = 8'($urandom_range(0, 255));
            push_char((ch == slc_pkg::ChCr || ch == slc_pkg::ChLf) ? "c" : ch);
          end
          push_char($urandom_range(0, 1) ? slc_pkg::ChCr : slc_pkg::ChLf);
        end
      end
      8, 9: push_char(pick_char(" \t\r\n  "));
      10: repeat ($urandom_range(1, 2)) push_char(8'($urandom_range(0, 255)));
      default: begin
        if ($urandom_range(0, 2) == 0)
          push_flush();
        else
          push_char(pick_char(" ;"));
      end
    endcase
  endtask

  initial begin
    int n_directed;
    // numbers, idle space, double from a lone dot, identifier, operator
    push_text("12.5  .7x=");
    // string with spaces, a known and an unknown escape
    push_text("\" \t\\n\\q\"");
    // a comment ended by CR; a single slash then falls through to append, and LF does not end it
    push_text("//a\r/b\n");
    push_char(8'hff);
    push_char(8'h00);
    // flush with an escape pending, then flush while idle
    push_text("\"\\");
    push_flush();
    push_flush();
    n_directed = src_items.size();

    while (src_items.size() < n_directed + 90)
      add_token();

    push_flush();
    push_text("x\r ");
    push_flush();
    push_text("7");
    push_flush();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (src_items.size() != 0 || lex_events_due.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && lex_events_due.size() == 0)
      $display("** source_lexer_char_classifier: PASSED **");
    else
      $display("** source_lexer_char_classifier: FAILED **");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("** source_lexer_char_classifier: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- driver
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        lex_step(src_items.pop_front());
      // an item that was not taken stays on the bus unchanged
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0 || src_items.size() == 0) begin
          if (gap_left > 0)
            gap_left--;
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tuser  <= src_items[0].flush;
          s_tdata  <= src_items[0].ch;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = $urandom_range(0, 1) ? $urandom_range(1, 4) : 0;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int rx_cyc = 0;
  int rx_mode = 0;

  task automatic check_field(input string name, input logic [31:0] expv,
                             input logic [31:0] got);
    if (got !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (lex_events_due.size() == 0) begin
          $error("event with nothing expected: kind %0d data %h", m_tuser, m_tdata);
          mismatches++;
        end else begin
          want = lex_events_due.pop_front();
          check_field("event_kind", 32'(want.kind), 32'(m_tuser));
          check_field("token_class", 32'(want.cls), 32'(m_tdata[2:0]));
          check_field("char_value", 32'(want.ch), 32'(m_tdata[10:3]));
          check_field("line_number", 32'(want.line), 32'(m_tdata[26:11]));
          check_field("last_event", 32'(want.last), 32'(m_tlast));
        end
      end
      rx_cyc++;
      if (rx_cyc % 50 == 0)
        rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (rx_cyc % 7 < 4);
      endcase
    end
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/slc_pkg.sv
sv/slc_lexer.sv
sv/slc_serializer.sv
sv/source_lexer_char_classifier.sv
sv/slc_checker.sv
tb/sv/source_lexer_char_classifier_tb.sv
